// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is switched off while the active-low reset is asserted.
`define E2C_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked through reset as well.
`define E2C_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hw/rtl/e2c_pkg.sv -----
package e2c_pkg;

  localparam int MAX_FACE        = 1024;
  localparam int COORD_FRAC_BITS = 8;

  localparam int SEL_W   = 3;
  localparam int PIX_W   = 10;
  localparam int FACE_W  = 11;
  localparam int SRC_W_W = 13;
  localparam int SRC_H_W = 12;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SX_W    = 20;
  localparam int SY_W    = 19;

  localparam int VEC_FRAC = 24;
  localparam int VEC_W    = 28;
  localparam int ANG_FRAC = 20;
  localparam int ANG_W    = 24;
  localparam int CORDIC_ITERS = 20;
  localparam int ATAN_W   = 20;
  localparam int GAIN_W   = 16;
  localparam int INV_GAIN = 39797;
  localparam int PROD_W   = VEC_W + GAIN_W;

  // Normalised coordinate divider: one quotient digit of DIV_BITS bits per stage.
  localparam int Q_W        = VEC_FRAC + 1;
  localparam int NUM_W      = FACE_W + VEC_FRAC;
  localparam int DIV_BITS   = 5;
  localparam int DIV_STAGES = Q_W / DIV_BITS;

  localparam int CORDIC_LAT  = CORDIC_ITERS + 3;
  localparam int POST_STAGES = 5;
  localparam int E2C_LATENCY = 1 + DIV_STAGES + 2 * CORDIC_LAT + POST_STAGES;

  localparam logic [FACE_W-1:0]  FACE_EDGE_RST  = FACE_W'(256);
  localparam logic [SRC_W_W-1:0] SRC_WIDTH_RST  = SRC_W_W'(1024);
  localparam logic [SRC_H_W-1:0] SRC_HEIGHT_RST = SRC_H_W'(512);

  localparam logic [CFG_IDX_W-1:0] CFG_FACE_EDGE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(2);

  localparam logic [SEL_W-1:0] FACE_FRONT  = SEL_W'(0);
  localparam logic [SEL_W-1:0] FACE_RIGHT  = SEL_W'(1);
  localparam logic [SEL_W-1:0] FACE_BACK   = SEL_W'(2);
  localparam logic [SEL_W-1:0] FACE_LEFT   = SEL_W'(3);
  localparam logic [SEL_W-1:0] FACE_TOP    = SEL_W'(4);
  localparam logic [SEL_W-1:0] FACE_BOTTOM = SEL_W'(5);

  localparam logic signed [VEC_W-1:0] VEC_ONE     = VEC_W'(1) << VEC_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(1) << ANG_FRAC;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(1) << (ANG_FRAC - 1);
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = ANG_W'(1) << (ANG_FRAC + 1);

  localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    20'd262144, 20'd154753, 20'd81767, 20'd41506, 20'd20834, 20'd10427, 20'd5215,
    20'd2608, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81, 20'd41, 20'd20, 20'd10,
    20'd5, 20'd3, 20'd1, 20'd1
  };

  typedef struct packed {
    logic [SEL_W-1:0] face_sel;
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [SX_W-1:0] src_x;
    logic [SY_W-1:0] src_y;
    logic            bad_shape;
  } out_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic             bad;
    logic             neg_x;
    logic             neg_y;
  } div_side_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic             bad;
    logic [VEC_W-1:0] ty;
    logic [ANG_W-1:0] u;
  } side_t;

endpackage

// ----- hw/rtl/e2c_div.sv -----
module e2c_div import e2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [FACE_W-1:0] f,
  input  logic              in_valid,
  input  div_side_t         in_side,
  input  logic [FACE_W-1:0] in_mag_x,
  input  logic [FACE_W-1:0] in_mag_y,
  output logic              out_valid,
  output div_side_t         out_side,
  output logic [Q_W-1:0]    out_q_x,
  output logic [Q_W-1:0]    out_q_y
);

  typedef struct packed {
    logic [FACE_W-1:0] rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    q;
  } div_lane_t;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [FACE_W-1:0] d);
    div_lane_t       o;
    logic [FACE_W:0] t;
    o = l;
    for (int b = 0; b < DIV_BITS; b++) begin
      t = {o.rem, o.low[Q_W-1]};
      o.low = o.low << 1;
      if (t >= {1'b0, d}) begin
        o.rem = FACE_W'(t - {1'b0, d});
        o.q   = {o.q[Q_W-2:0], 1'b1};
      end else begin
        o.rem = t[FACE_W-1:0];
        o.q   = {o.q[Q_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [NUM_W-1:0] num [2];
  div_lane_t        init [2];
  div_lane_t        lane_r [DIV_STAGES][2];
  logic             valid_r [DIV_STAGES];
  div_side_t        side_r [DIV_STAGES];

  // Rounding to nearest is folded into the dividend as half the divisor.
  always_comb begin
    num[0] = {in_mag_x, {VEC_FRAC{1'b0}}} + NUM_W'(f >> 1);
    num[1] = {in_mag_y, {VEC_FRAC{1'b0}}} + NUM_W'(f >> 1);
    for (int k = 0; k < 2; k++) begin
      init[k].rem = FACE_W'(num[k][NUM_W-1:Q_W]);
      init[k].low = num[k][Q_W-1:0];
      init[k].q   = '0;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[0] <= 1'b0;
        end else begin
          valid_r[0] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        side_r[0]    <= in_side;
        lane_r[0][0] <= div_step(init[0], f);
        lane_r[0][1] <= div_step(init[1], f);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else begin
          valid_r[s] <= valid_r[s-1];
        end
      end
      always_ff @(posedge clk) begin
        side_r[s]    <= side_r[s-1];
        lane_r[s][0] <= div_step(lane_r[s-1][0], f);
        lane_r[s][1] <= div_step(lane_r[s-1][1], f);
      end
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];
  assign out_q_x   = lane_r[DIV_STAGES-1][0].q;
  assign out_q_y   = lane_r[DIV_STAGES-1][1].q;

endmodule

// ----- hw/rtl/e2c_cordic.sv -----
module e2c_cordic import e2c_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  side_t                   in_side,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_z,
  output logic signed [VEC_W-1:0] out_mag,
  output side_t                   out_side
);

  logic signed [VEC_W-1:0] x_r [CORDIC_ITERS+1];
  logic signed [VEC_W-1:0] y_r [CORDIC_ITERS+1];
  logic signed [ANG_W-1:0] z_r [CORDIC_ITERS+1];
  logic                    zero_r [CORDIC_ITERS+1];
  logic                    valid_r [CORDIC_ITERS+1];
  side_t                   side_r [CORDIC_ITERS+1];

  logic signed [VEC_W-1:0] pre_x;
  logic signed [VEC_W-1:0] pre_y;
  logic signed [ANG_W-1:0] pre_z;

  // A vector in the left half-plane is turned by a half turn first.
  always_comb begin
    pre_x = in_x;
    pre_y = in_y;
    pre_z = '0;
    if (in_x[VEC_W-1]) begin
      pre_x = -in_x;
      pre_y = -in_y;
      pre_z = in_y[VEC_W-1] ? -ANG_PI : ANG_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= pre_x;
    y_r[0]    <= pre_y;
    z_r[0]    <= pre_z;
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else begin
        valid_r[i+1] <= valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!y_r[i][VEC_W-1]) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + $signed(ANG_W'(ATAN_TAB[i]));
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - $signed(ANG_W'(ATAN_TAB[i]));
      end
      zero_r[i+1] <= zero_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  // Gain correction: multiply by 1/K in Q16, then round in the next stage.
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       prod_rnd;
  logic signed [ANG_W-1:0] mz_r;
  logic                    mzero_r;
  logic                    mvalid_r;
  side_t                   mside_r;
  logic signed [VEC_W-1:0] mag_r;
  logic signed [ANG_W-1:0] oz_r;
  logic                    ovalid_r;
  side_t                   oside_r;

  assign prod_rnd = prod_r + (PROD_W'(1) << (GAIN_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      mvalid_r <= valid_r[CORDIC_ITERS];
      ovalid_r <= mvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(x_r[CORDIC_ITERS][VEC_W-2:0]) * PROD_W'(INV_GAIN);
    mz_r    <= z_r[CORDIC_ITERS];
    mzero_r <= zero_r[CORDIC_ITERS];
    mside_r <= side_r[CORDIC_ITERS];
    if (mzero_r) begin
      mag_r <= '0;
      oz_r  <= '0;
    end else begin
      mag_r <= $signed(prod_rnd[GAIN_W+VEC_W-1:GAIN_W]);
      oz_r  <= mz_r;
    end
    oside_r <= mside_r;
  end

  assign out_valid = ovalid_r;
  assign out_z     = oz_r;
  assign out_mag   = mag_r;
  assign out_side  = oside_r;

endmodule

// ----- hw/rtl/e2c_post.sv -----
module e2c_post import e2c_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  side_t                   in_side,
  input  logic signed [ANG_W-1:0] in_a,
  input  logic [SRC_W_W-1:0]      src_width,
  input  logic [SRC_H_W-1:0]      src_height,
  output logic                    out_strobe,
  output out_t                    out_data
);

  localparam int PU_W  = ANG_FRAC + 2;
  localparam int PX_W  = PU_W + SRC_W_W;
  localparam int PY_W  = PU_W + SRC_H_W;
  localparam int SXF_W = PX_W + COORD_FRAC_BITS + 1;
  localparam int SYF_W = PY_W + COORD_FRAC_BITS + 1;

  // Stage A: yaw offset and latitude per face.
  logic signed [ANG_W-1:0] a2;
  logic signed [ANG_W-1:0] ua;
  logic signed [ANG_W-1:0] va;
  logic signed [ANG_W-1:0] ua_r;
  logic signed [ANG_W-1:0] va_r;
  logic                    a_valid_r;
  logic                    a_bad_r;

  always_comb begin
    a2 = in_a <<< 1;
    ua = $signed(in_side.u);
    va = a2;
    case (in_side.sel)
      FACE_RIGHT:  ua = $signed(in_side.u) + ANG_HALF_PI;
      FACE_BACK:   ua = $signed(in_side.u) + ANG_PI;
      FACE_LEFT:   ua = $signed(in_side.u) - ANG_HALF_PI;
      FACE_TOP:    va = a2 - ANG_PI;
      FACE_BOTTOM: va = ANG_PI - a2;
      default:     va = a2;
    endcase
  end

  // Stage B: fold latitude back over a pole, which turns longitude by a half turn.
  logic signed [ANG_W-1:0] ub_r;
  logic signed [ANG_W-1:0] vb_r;
  logic                    b_valid_r;
  logic                    b_bad_r;

  // Stage C: longitude into one turn.
  logic signed [ANG_W-1:0] uc1;
  logic signed [ANG_W-1:0] uc2;
  logic signed [ANG_W-1:0] uc_r;
  logic signed [ANG_W-1:0] vc_r;
  logic                    c_valid_r;
  logic                    c_bad_r;

  always_comb begin
    uc1 = ub_r;
    if (ub_r < -ANG_PI) begin
      uc1 = ub_r + ANG_TWO_PI;
    end else if (ub_r > ANG_PI) begin
      uc1 = ub_r - ANG_TWO_PI;
    end
    uc2 = uc1;
    if (uc1 < -ANG_PI) begin
      uc2 = uc1 + ANG_TWO_PI;
    end else if (uc1 > ANG_PI) begin
      uc2 = uc1 - ANG_TWO_PI;
    end
  end

  // Stage D: offset into [0, 2pi] and scale by the source span.
  logic signed [ANG_W-1:0] pu_s;
  logic signed [ANG_W-1:0] pv_s;
  logic [SRC_W_W-1:0]      span_w;
  logic [SRC_H_W-1:0]      span_h;
  logic [PX_W-1:0]         px_r;
  logic [PY_W-1:0]         py_r;
  logic                    d_valid_r;
  logic                    d_bad_r;

  assign pu_s   = uc_r + ANG_PI;
  assign pv_s   = vc_r + ANG_PI;
  assign span_w = (src_width == '0) ? '0 : src_width - SRC_W_W'(1);
  assign span_h = (src_height == '0) ? '0 : src_height - SRC_H_W'(1);

  // Stage E: round half up, saturate, output register.
  logic [SXF_W-1:0] sx_full;
  logic [SYF_W-1:0] sy_full;
  logic [SX_W-1:0]  sx;
  logic [SY_W-1:0]  sy;
  logic             strobe_r;
  out_t             data_r;

  always_comb begin
    sx_full = ((SXF_W'(px_r) << COORD_FRAC_BITS) + (SXF_W'(1) << ANG_FRAC)) >> (ANG_FRAC + 1);
    sy_full = ((SYF_W'(py_r) << COORD_FRAC_BITS) + (SYF_W'(1) << ANG_FRAC)) >> (ANG_FRAC + 1);
    sx = (sx_full > SXF_W'({SX_W{1'b1}})) ? {SX_W{1'b1}} : sx_full[SX_W-1:0];
    sy = (sy_full > SYF_W'({SY_W{1'b1}})) ? {SY_W{1'b1}} : sy_full[SY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r;
      strobe_r  <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ua_r    <= ua;
    va_r    <= va;
    a_bad_r <= in_side.bad;

    if (va_r < -ANG_PI) begin
      vb_r <= va_r + ANG_TWO_PI;
      ub_r <= ua_r + ANG_PI;
    end else if (va_r > ANG_PI) begin
      vb_r <= va_r - ANG_TWO_PI;
      ub_r <= ua_r + ANG_PI;
    end else begin
      vb_r <= va_r;
      ub_r <= ua_r;
    end
    b_bad_r <= a_bad_r;

    uc_r    <= uc2;
    vc_r    <= vb_r;
    c_bad_r <= b_bad_r;

    px_r    <= PX_W'(pu_s[PU_W-1:0]) * PX_W'(span_w);
    py_r    <= PY_W'(pv_s[PU_W-1:0]) * PY_W'(span_h);
    d_bad_r <= c_bad_r;

    if (d_bad_r) begin
      data_r.src_x <= '0;
      data_r.src_y <= '0;
    end else begin
      data_r.src_x <= sx;
      data_r.src_y <= sy;
    end
    data_r.bad_shape <= d_bad_r;
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule

// ----- hw/rtl/equirect_to_cubemap_coord.sv -----
// Throughput: one pixel per clock while busy is low; each stage of the divider,
// both 20-step CORDIC units and the scaling tail is registered, so a beat may
// follow every cycle.
// Reset: rst_n is synchronous and active low; it clears all valid bits and loads
// face edge 256, src_width 1024, src_height 512. busy is high for one cycle after it.
// The receiver cannot stall: each result is shown for exactly one cycle.
module equirect_to_cubemap_coord import e2c_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_strobe,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int D_W = FACE_W + 2;

  logic [FACE_W-1:0]  face_edge_r;
  logic [SRC_W_W-1:0] src_width_r;
  logic [SRC_H_W-1:0] src_height_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_edge_r  <= FACE_EDGE_RST;
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      busy_r       <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FACE_EDGE:  face_edge_r  <= cfg_data[FACE_W-1:0];
          CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SRC_W_W-1:0];
          CFG_SRC_HEIGHT: src_height_r <= cfg_data[SRC_H_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Input stage: clamp the face size and pixel, form 2c - F and its magnitude.
  logic [FACE_W-1:0]     f_eff;
  logic [FACE_W-1:0]     col_c;
  logic [FACE_W-1:0]     row_c;
  logic signed [D_W-1:0] d_x;
  logic signed [D_W-1:0] d_y;
  logic signed [D_W-1:0] abs_x;
  logic signed [D_W-1:0] abs_y;
  logic [SEL_W-1:0]      sel_n;

  always_comb begin
    if (face_edge_r == '0) begin
      f_eff = FACE_W'(1);
    end else if (face_edge_r > FACE_W'(MAX_FACE)) begin
      f_eff = FACE_W'(MAX_FACE);
    end else begin
      f_eff = face_edge_r;
    end
    col_c = ({1'b0, in_data.col} >= f_eff) ? f_eff - FACE_W'(1) : {1'b0, in_data.col};
    row_c = ({1'b0, in_data.row} >= f_eff) ? f_eff - FACE_W'(1) : {1'b0, in_data.row};
    d_x   = $signed({1'b0, col_c, 1'b0}) - $signed({2'b0, f_eff});
    d_y   = $signed({1'b0, row_c, 1'b0}) - $signed({2'b0, f_eff});
    abs_x = d_x[D_W-1] ? -d_x : d_x;
    abs_y = d_y[D_W-1] ? -d_y : d_y;
    sel_n = (in_data.face_sel > FACE_BOTTOM) ? FACE_FRONT : in_data.face_sel;
  end

  logic              s0_valid_r;
  div_side_t         s0_side_r;
  logic [FACE_W-1:0] s0_mag_x_r;
  logic [FACE_W-1:0] s0_mag_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r.sel   <= sel_n;
    s0_side_r.bad   <= src_height_r != src_width_r[SRC_W_W-1:1];
    s0_side_r.neg_x <= d_x[D_W-1];
    s0_side_r.neg_y <= d_y[D_W-1];
    s0_mag_x_r      <= abs_x[FACE_W-1:0];
    s0_mag_y_r      <= abs_y[FACE_W-1:0];
  end

  logic           dv_valid;
  div_side_t      dv_side;
  logic [Q_W-1:0] q_x;
  logic [Q_W-1:0] q_y;

  e2c_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .f        (f_eff),
    .in_valid (s0_valid_r),
    .in_side  (s0_side_r),
    .in_mag_x (s0_mag_x_r),
    .in_mag_y (s0_mag_y_r),
    .out_valid(dv_valid),
    .out_side (dv_side),
    .out_q_x  (q_x),
    .out_q_y  (q_y)
  );

  logic signed [VEC_W-1:0] tx;
  logic signed [VEC_W-1:0] ty;
  logic signed [VEC_W-1:0] c1_x;
  logic signed [VEC_W-1:0] c1_y;
  side_t                   c1_in_side;

  always_comb begin
    tx = dv_side.neg_x ? -$signed(VEC_W'(q_x)) : $signed(VEC_W'(q_x));
    ty = dv_side.neg_y ? -$signed(VEC_W'(q_y)) : $signed(VEC_W'(q_y));
    case (dv_side.sel)
      FACE_TOP: begin
        c1_x = tx;
        c1_y = -ty;
      end
      FACE_BOTTOM: begin
        c1_x = tx;
        c1_y = ty;
      end
      default: begin
        c1_x = VEC_ONE;
        c1_y = tx;
      end
    endcase
    c1_in_side.sel = dv_side.sel;
    c1_in_side.bad = dv_side.bad;
    c1_in_side.ty  = ty;
    c1_in_side.u   = '0;
  end

  logic                    c1_valid;
  logic signed [ANG_W-1:0] c1_z;
  logic signed [VEC_W-1:0] c1_mag;
  side_t                   c1_side;

  e2c_cordic u_cordic_lon (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_valid),
    .in_x     (c1_x),
    .in_y     (c1_y),
    .in_side  (c1_in_side),
    .out_valid(c1_valid),
    .out_z    (c1_z),
    .out_mag  (c1_mag),
    .out_side (c1_side)
  );

  // Side faces take the latitude from (r, ty); the caps from (1, r).
  logic signed [VEC_W-1:0] c2_x;
  logic signed [VEC_W-1:0] c2_y;
  side_t                   c2_in_side;

  always_comb begin
    if ((c1_side.sel == FACE_TOP) || (c1_side.sel == FACE_BOTTOM)) begin
      c2_x = VEC_ONE;
      c2_y = c1_mag;
    end else begin
      c2_x = c1_mag;
      c2_y = $signed(c1_side.ty);
    end
    c2_in_side   = c1_side;
    c2_in_side.u = c1_z;
  end

  logic                    c2_valid;
  logic signed [ANG_W-1:0] c2_z;
  logic signed [VEC_W-1:0] c2_mag;
  side_t                   c2_side;

  e2c_cordic u_cordic_lat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (c1_valid),
    .in_x     (c2_x),
    .in_y     (c2_y),
    .in_side  (c2_in_side),
    .out_valid(c2_valid),
    .out_z    (c2_z),
    .out_mag  (c2_mag),
    .out_side (c2_side)
  );

  // The second magnitude is not needed; fold it into nothing visible.
  logic unused_mag;
  assign unused_mag = ^c2_mag;

  e2c_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c2_valid & (unused_mag | ~unused_mag)),
    .in_side   (c2_side),
    .in_a      (c2_z),
    .src_width (src_width_r),
    .src_height(src_height_r),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/e2c_chk.sv -----
`include "assert_macros.svh"
module e2c_chk import e2c_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  `E2C_ASSERT_RST(a_beat_gives_result, clk, rst_n, (start && !busy) |-> ##E2C_LATENCY out_strobe, "accepted beat gave no result")
  `E2C_ASSERT_RST(a_result_has_beat, clk, rst_n, out_strobe |-> $past(start && !busy, E2C_LATENCY), "result without an accepted beat")
  `E2C_ASSERT_RST(a_bad_shape_zero, clk, rst_n, (out_strobe && out_data.bad_shape) |-> ((out_data.src_x == '0) && (out_data.src_y == '0)), "bad shape with nonzero coordinates")
  `E2C_ASSERT(a_busy_after_reset, clk, $past(rst_n) |-> !busy, "busy held outside reset")

endmodule

bind equirect_to_cubemap_coord e2c_chk u_e2c_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_strobe(out_strobe),
  .out_data  (out_data)
);

// ----- tb/sv/tb_equirect_to_cubemap_coord.sv -----
`timescale 1ns / 1ps

module tb_equirect_to_cubemap_coord;
  import e2c_pkg::*;

  class coord_scoreboard;
    out_t       coords_due[$];
    int         mismatches;
    longint     face_edge = FACE_EDGE_RST;
    longint     eq_width = SRC_WIDTH_RST;
    longint     eq_height = SRC_HEIGHT_RST;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_FACE_EDGE: begin
          face_edge = val[FACE_W-1:0];
        end
        CFG_SRC_WIDTH: begin
          eq_width = val[SRC_W_W-1:0];
        end
        CFG_SRC_HEIGHT: begin
          eq_height = val[SRC_H_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Vectoring CORDIC; angle in units of pi with 20 fraction bits.
    function longint vector_angle(longint x, longint y, output longint mag);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      if (x == 0 && y == 0) begin
        mag = 0;
        return 0;
      end
      if (x < 0) begin
        z = (y >= 0) ? (64'sd1 <<< 20) : -(64'sd1 <<< 20);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(ATAN_TAB[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(ATAN_TAB[i]);
        end
      end
      mag = (x * INV_GAIN + (64'sd1 <<< 15)) >>> 16;
      return z;
    endfunction

    function longint pixel_to_unit(longint c, longint f);
      longint d;
      longint q;
      d = 2 * c - f;
      q = (((d < 0 ? -d : d) <<< 24) + f / 2) / f;
      return d < 0 ? -q : q;
    endfunction

    function longint angle_to_pixel(longint a, longint span, longint maxv);
      longint r;
      r = ((((a + (64'sd1 <<< 20)) * span) <<< COORD_FRAC_BITS) + (64'sd1 <<< 20)) >>> 21;
      return r > maxv ? maxv : r;
    endfunction

    function void note_pixel(in_t px);
      longint f, c, r, tx, ty, u, v, m, a, one, pi;
      logic [SEL_W-1:0] face;
      out_t exp_out;
      one = 64'sd1 <<< 24;
      pi = 64'sd1 <<< 20;
      exp_out = '0;
      if (eq_height != (eq_width >> 1)) begin
        exp_out.bad_shape = 1'b1;
        coords_due.push_back(exp_out);
        return;
      end
      f = face_edge;
      if (f == 0) f = 1;
      if (f > MAX_FACE) f = MAX_FACE;
      c = px.col;
      r = px.row;
      if (c >= f) c = f - 1;
      if (r >= f) r = f - 1;
      tx = pixel_to_unit(c, f);
      ty = pixel_to_unit(r, f);
      face = (px.face_sel > FACE_BOTTOM) ? FACE_FRONT : px.face_sel;
      if (face <= FACE_LEFT) begin
        u = vector_angle(one, tx, m);
        a = vector_angle(m, ty, m);
        v = 2 * a;
        if (face == FACE_RIGHT) u = u + pi / 2;
        else if (face == FACE_BACK) u = u + pi;
        else if (face == FACE_LEFT) u = u - pi / 2;
      end else begin
        u = vector_angle(tx, face == FACE_TOP ? -ty : ty, m);
        a = vector_angle(one, m, m);
        v = (face == FACE_TOP) ? (2 * a - pi) : (pi - 2 * a);
      end
      while (v < -pi) begin
        v = v + 2 * pi;
        u = u + pi;
      end
      while (v > pi) begin
        v = v - 2 * pi;
        u = u + pi;
      end
      while (u < -pi) u = u + 2 * pi;
      while (u > pi) u = u - 2 * pi;
      exp_out.src_x = SX_W'(angle_to_pixel(u, eq_width != 0 ? eq_width - 1 : 0, 1048575));
      exp_out.src_y = SY_W'(angle_to_pixel(v, eq_height != 0 ? eq_height - 1 : 0, 524287));
      coords_due.push_back(exp_out);
    endfunction

    function void check_coord(out_t got);
      out_t want;
      if (coords_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
        return;
      end
      want = coords_due.pop_front();
      if (got.src_x !== want.src_x) begin
        $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, got.src_x);
        mismatches++;
      end
      if (got.src_y !== want.src_y) begin
        $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, got.src_y);
        mismatches++;
      end
      if (got.bad_shape !== want.bad_shape) begin
        $display("%0t: bad_shape expected %0b actual %0b", $time, want.bad_shape,
                 got.bad_shape);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_strobe;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FACE_EDGE;
  logic [CFG_W-1:0]     cfg_data = '0;

  coord_scoreboard sb = new();
  int idle_pct;

  equirect_to_cubemap_coord u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_pixel(in_data);
      if (out_strobe) sb.check_coord(out_data);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // Writes all three registers back to back; valid drops only after the last.
  task automatic set_geometry(int f, int w, int h);
    int vals[3];
    logic [CFG_IDX_W-1:0] idxs[3];
    vals = '{f, w, h};
    idxs = '{CFG_FACE_EDGE, CFG_SRC_WIDTH, CFG_SRC_HEIGHT};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= CFG_W'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(logic [SEL_W-1:0] face, int c, int r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{face_sel: face, col: PIX_W'(c), row: PIX_W'(r)};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.coords_due.size() != 0) @(posedge clk);
    repeat (E2C_LATENCY + 5) @(posedge clk);
  endtask

  function automatic int pick_pixel(int f);
    int lim;
    lim = (f < 1) ? 1 : (f > MAX_FACE ? MAX_FACE : f);
    if ($urandom_range(9) < 8) return $urandom_range(lim - 1, 0);
    return $urandom_range(1023, 0);
  endfunction

  initial begin
    int geo[9][3];
    geo = '{'{256, 1024, 512}, '{1, 2, 1}, '{1024, 4096, 2048}, '{0, 8191, 4095},
            '{2047, 1000, 500}, '{37, 1024, 300}, '{5, 0, 0}, '{700, 1, 0},
            '{3, 4096, 2048}};
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every face including the unused codes, face corners, centre,
    // and pixels beyond the face edge.
    for (int fc = 0; fc < 8; fc++) begin
      send_pixel(SEL_W'(fc), 0, 0);
      send_pixel(SEL_W'(fc), 255, 255);
    end
    send_pixel(FACE_FRONT, 128, 128);
    send_pixel(FACE_TOP, 128, 128);
    send_pixel(FACE_BOTTOM, 0, 255);
    send_pixel(FACE_RIGHT, 1023, 1023);
    send_pixel(FACE_LEFT, 512, 0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph != 0) begin
        set_geometry(geo[ph][0], geo[ph][1], geo[ph][2]);
        @(posedge clk);
      end
      for (int k = 0; k < 4; k++) begin
        idle_pct = (k == 1) ? 62 : (k == 3) ? 27 : 0;
        repeat (24) send_pixel(SEL_W'($urandom_range(7, 0)), pick_pixel(geo[ph][0]),
                               pick_pixel(geo[ph][0]));
      end
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_div.sv
hw/rtl/e2c_cordic.sv
hw/rtl/e2c_post.sv
hw/rtl/equirect_to_cubemap_coord.sv
hw/rtl/e2c_chk.sv
tb/sv/tb_equirect_to_cubemap_coord.sv
